// ----- src/m3inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants for the 3x3 matrix inverse: the cofactor operand table
// and a small width helper.
// ----------------------------------------------------------------------------
`default_nettype none

package m3inv_pkg;

  localparam int NUM_ELEM = 9;

  // Element k of the adjugate (row-major) is m[a]*m[b] - m[c]*m[d].
  localparam int COF_IDX [0:8][0:3] = '{
    '{4, 8, 5, 7},
    '{7, 2, 1, 8},
    '{1, 5, 4, 2},
    '{6, 5, 3, 8},
    '{0, 8, 6, 2},
    '{3, 2, 0, 5},
    '{3, 7, 6, 4},
    '{6, 1, 0, 7},
    '{0, 4, 3, 1}
  };

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- src/m3inv_in_if.sv -----
// ----------------------------------------------------------------------------
// m3inv_in_if
// Request channel carrying one 3x3 matrix in row order.
// ----------------------------------------------------------------------------
`default_nettype none

interface m3inv_in_if #(
  parameter int ELEM_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] m00;
  logic signed [ELEM_WIDTH-1:0] m01;
  logic signed [ELEM_WIDTH-1:0] m02;
  logic signed [ELEM_WIDTH-1:0] m10;
  logic signed [ELEM_WIDTH-1:0] m11;
  logic signed [ELEM_WIDTH-1:0] m12;
  logic signed [ELEM_WIDTH-1:0] m20;
  logic signed [ELEM_WIDTH-1:0] m21;
  logic signed [ELEM_WIDTH-1:0] m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/m3inv_out_if.sv -----
// ----------------------------------------------------------------------------
// m3inv_out_if
// Result channel carrying the inverse matrix and its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface m3inv_out_if #(
  parameter int ELEM_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] r00;
  logic signed [ELEM_WIDTH-1:0] r01;
  logic signed [ELEM_WIDTH-1:0] r02;
  logic signed [ELEM_WIDTH-1:0] r10;
  logic signed [ELEM_WIDTH-1:0] r11;
  logic signed [ELEM_WIDTH-1:0] r12;
  logic signed [ELEM_WIDTH-1:0] r20;
  logic signed [ELEM_WIDTH-1:0] r21;
  logic signed [ELEM_WIDTH-1:0] r22;
  logic                         singular;
  logic                         saturated;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// Fixed-point 3x3 matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
// The block accepts one matrix per clock cycle unless the result channel
// stalls the pipeline. Eight stages form the products, cofactors, exact
// determinant, singularity test and rounded dividends; the nine divisions
// then run as nine parallel restoring dividers that settle one quotient bit
// per stage, which sets the depth. Every stage stalls only when the stage
// after it is full, so bubbles are squeezed out while the result channel is
// held.
`default_nettype none

module matrix3_inverse #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata,
  m3inv_in_if.sink         in_chan,
  m3inv_out_if.source      out_chan
);
  import m3inv_pkg::*;

  localparam int E    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * E;
  localparam int CW   = 2 * E + 1;
  localparam int PPW  = 2 * E + 1;
  localparam int DW   = 3 * E + 3;
  localparam int LMW  = 31 + 2 * F;
  localparam int CMPW = max_int(DW, LMW);
  localparam int NW   = max_int(CW + 2 * F + 1, DW) + 1;
  localparam int BW   = max_int(NW, DW + 1) + 1;
  localparam int NS   = E + 10;
  localparam int SDIV = 8;
  localparam logic [E-1:0] MAXP    = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MINN    = {1'b1, {(E-1){1'b0}}};
  localparam bit           ONE_CLP = (F >= E - 1);
  localparam logic [E-1:0] ONE_VAL = ONE_CLP ? MAXP : (E'(1) << F);

  logic [30:0] thr;
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic signed [E-1:0]   in_m  [NUM_ELEM];
  logic signed [E-1:0]   m_q   [NUM_ELEM];
  logic signed [PW-1:0]  pa    [NUM_ELEM];
  logic signed [PW-1:0]  pb    [NUM_ELEM];
  logic signed [E-1:0]   row1  [3];
  logic signed [E-1:0]   row2  [3];
  logic signed [CW-1:0]  cof2  [NUM_ELEM];
  logic signed [CW-1:0]  cof3  [NUM_ELEM];
  logic signed [CW-1:0]  cof4  [NUM_ELEM];
  logic signed [CW-1:0]  cof5  [NUM_ELEM];
  logic signed [PPW-1:0] pl    [3];
  logic signed [PPW-1:0] ph    [3];
  logic signed [DW-1:0]  term  [3];
  logic signed [DW-1:0]  det;
  logic [DW-1:0]         ad;
  logic                  dneg;
  logic [CW-1:0]         ca    [NUM_ELEM];
  logic                  cneg  [NUM_ELEM];
  logic [BW-1:0]         nn    [NUM_ELEM];
  logic [BW-1:0]         dd;
  logic                  neg7  [NUM_ELEM];
  logic                  sing7;

  logic [BW-1:0]         rem    [E+1][NUM_ELEM];
  logic [E-1:0]          quo    [E+1][NUM_ELEM];
  logic                  over_d [E+1][NUM_ELEM];
  logic                  neg_d  [E+1][NUM_ELEM];
  logic [BW-1:0]         dd_d   [E+1];
  logic                  sing_d [E+1];

  logic [E-1:0]          res_val  [NUM_ELEM];
  logic [NUM_ELEM-1:0]   res_clip;
  logic [E-1:0]          out_r    [NUM_ELEM];
  logic                  out_sing;
  logic                  out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 31'd1;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_comb begin
    en[NS-1] = !v[NS-1] || out_chan.ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_chan.valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_comb begin
    in_m[0] = in_chan.m00;
    in_m[1] = in_chan.m01;
    in_m[2] = in_chan.m02;
    in_m[3] = in_chan.m10;
    in_m[4] = in_chan.m11;
    in_m[5] = in_chan.m12;
    in_m[6] = in_chan.m20;
    in_m[7] = in_chan.m21;
    in_m[8] = in_chan.m22;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_q <= in_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        pa[k] <= m_q[COF_IDX[k][0]] * m_q[COF_IDX[k][1]];
        pb[k] <= m_q[COF_IDX[k][2]] * m_q[COF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
        row1[j] <= m_q[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        cof2[k] <= CW'(pa[k]) - CW'(pb[k]);
      end
      row2 <= row1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        pl[j] <= row2[j] * $signed({1'b0, cof2[3*j][E-1:0]});
        ph[j] <= row2[j] * $signed(cof2[3*j][CW-1:E]);
      end
      cof3 <= cof2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= (DW'(ph[j]) <<< E) + DW'(pl[j]);
      end
      cof4 <= cof3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      det  <= term[0] + term[1] + term[2];
      cof5 <= cof4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      dneg <= det[DW-1];
      ad   <= det[DW-1] ? (~det + DW'(1)) : det;
      for (int k = 0; k < NUM_ELEM; k++) begin
        cneg[k] <= cof5[k][CW-1];
        ca[k]   <= cof5[k][CW-1] ? (~cof5[k] + CW'(1)) : cof5[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sing7 <= CMPW'(ad) <= (CMPW'(thr) << (2 * F));
      dd    <= BW'(ad) << 1;
      for (int k = 0; k < NUM_ELEM; k++) begin
        nn[k]   <= (BW'(ca[k]) << (2 * F + 1)) + BW'(ad);
        neg7[k] <= cneg[k] ^ dneg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[SDIV]) begin
      dd_d[0]   <= dd;
      sing_d[0] <= sing7;
      for (int k = 0; k < NUM_ELEM; k++) begin
        rem[0][k]    <= nn[k];
        quo[0][k]    <= '0;
        over_d[0][k] <= (nn[k] >> E) >= dd;
        neg_d[0][k]  <= neg7[k];
      end
    end
  end

  for (genvar s = 1; s <= E; s++) begin : g_div
    localparam int I = E - s;
    always_ff @(posedge clk) begin
      if (en[SDIV+s]) begin
        dd_d[s]   <= dd_d[s-1];
        sing_d[s] <= sing_d[s-1];
        for (int k = 0; k < NUM_ELEM; k++) begin
          over_d[s][k] <= over_d[s-1][k];
          neg_d[s][k]  <= neg_d[s-1][k];
          if ((rem[s-1][k] >> I) >= dd_d[s-1]) begin
            rem[s][k] <= rem[s-1][k] - (dd_d[s-1] << I);
            quo[s][k] <= quo[s-1][k] | (E'(1) << I);
          end else begin
            rem[s][k] <= rem[s-1][k];
            quo[s][k] <= quo[s-1][k];
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      if (sing_d[E]) begin
        if (k == 0 || k == 4 || k == 8) begin
          res_val[k]  = ONE_VAL;
          res_clip[k] = ONE_CLP;
        end else begin
          res_val[k]  = '0;
          res_clip[k] = 1'b0;
        end
      end else if (over_d[E][k]) begin
        res_val[k]  = neg_d[E][k] ? MINN : MAXP;
        res_clip[k] = 1'b1;
      end else if (neg_d[E][k]) begin
        res_clip[k] = quo[E][k] > MINN;
        res_val[k]  = res_clip[k] ? MINN : (~quo[E][k] + E'(1));
      end else begin
        res_clip[k] = quo[E][k] > MAXP;
        res_val[k]  = res_clip[k] ? MAXP : quo[E][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r    <= res_val;
      out_sing <= sing_d[E];
      out_sat  <= |res_clip;
    end
  end

  assign out_chan.valid     = v[NS-1];
  assign out_chan.r00       = out_r[0];
  assign out_chan.r01       = out_r[1];
  assign out_chan.r02       = out_r[2];
  assign out_chan.r10       = out_r[3];
  assign out_chan.r11       = out_r[4];
  assign out_chan.r12       = out_r[5];
  assign out_chan.r20       = out_r[6];
  assign out_chan.r21       = out_r[7];
  assign out_chan.r22       = out_r[8];
  assign out_chan.singular  = out_sing;
  assign out_chan.saturated = out_sat;

endmodule

`default_nettype wire

// ----- src/m3inv_checker.sv -----
// ----------------------------------------------------------------------------
// m3inv_checker
// Port-level checks for the matrix inverse, bound into matrix3_inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module m3inv_checker #(
  parameter int ELEM_WIDTH = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_singular,
  input wire logic [ELEM_WIDTH-1:0] r01,
  input wire logic [ELEM_WIDTH-1:0] r02,
  input wire logic [ELEM_WIDTH-1:0] r10,
  input wire logic [ELEM_WIDTH-1:0] r12,
  input wire logic [ELEM_WIDTH-1:0] r20,
  input wire logic [ELEM_WIDTH-1:0] r21
);

  // A pending result is never withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A request offered while the output is empty is always taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> in_ready)
    else $error("request refused with an empty output");

  // A singular result carries zeros off the diagonal.
  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_singular |->
      r01 == '0 && r02 == '0 && r10 == '0 && r12 == '0 && r20 == '0 && r21 == '0)
    else $error("singular result is not the identity");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result present right after reset");

  // A stalled result keeps its off-diagonal data and its singular flag.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(r01) && $stable(r02) && $stable(r10) && $stable(r12)
      && $stable(r20) && $stable(r21) && $stable(out_singular))
    else $error("result data changed while stalled");

endmodule

bind matrix3_inverse m3inv_checker #(
  .ELEM_WIDTH(ELEM_WIDTH)
) u_m3inv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_singular (out_chan.singular),
  .r01          (out_chan.r01),
  .r02          (out_chan.r02),
  .r10          (out_chan.r10),
  .r12          (out_chan.r12),
  .r20          (out_chan.r20),
  .r21          (out_chan.r21)
);

`default_nettype wire

// ----- sim/matrix3_inverse_test.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_test
// Streams 3x3 Q16.16 matrices through the inverse under random sender
// bursts and receiver stalls, predicts each inverse with wide exact
// arithmetic, and compares every returned field in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_test;

  localparam int FRAC = 16;
  localparam int EW = 32;
  localparam int LATENCY = EW + 10;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [0:8];

  typedef struct {
    mat_t r;
    logic singular;
    logic saturated;
  } inverse_t;

  typedef struct {
    mat_t m;
    logic has_lit;
    inverse_t lit;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic [30:0] threshold;
  longint cycles = 0;
  int errors = 0;
  inverse_t inverse_queue [$];
  row_t directed [$];

  m3inv_in_if #(.ELEM_WIDTH(EW)) in_chan ();
  m3inv_out_if #(.ELEM_WIDTH(EW)) out_chan ();

  matrix3_inverse #(.FRAC_BITS(FRAC), .ELEM_WIDTH(EW)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_chan(in_chan), .out_chan(out_chan)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic inverse_t predict_inverse(mat_t m, logic [30:0] thr);
    logic signed [255:0] mw [0:8];
    logic signed [255:0] c [0:8];
    logic signed [255:0] det, ad, num, q, lim;
    inverse_t res;
    logic sgn;
    for (int i = 0; i < 9; i++) mw[i] = m[i];
    c[0] = mw[4]*mw[8] - mw[5]*mw[7];
    c[1] = mw[7]*mw[2] - mw[1]*mw[8];
    c[2] = mw[1]*mw[5] - mw[4]*mw[2];
    c[3] = mw[6]*mw[5] - mw[3]*mw[8];
    c[4] = mw[0]*mw[8] - mw[6]*mw[2];
    c[5] = mw[3]*mw[2] - mw[0]*mw[5];
    c[6] = mw[3]*mw[7] - mw[6]*mw[4];
    c[7] = mw[6]*mw[1] - mw[0]*mw[7];
    c[8] = mw[0]*mw[4] - mw[3]*mw[1];
    det = mw[0]*c[0] + mw[1]*c[3] + mw[2]*c[6];
    ad = (det < 0) ? -det : det;
    lim = $signed({225'd0, thr}) <<< (2*FRAC);
    res.saturated = 1'b0;
    if (ad <= lim) begin
      for (int i = 0; i < 9; i++) res.r[i] = (i % 4 == 0) ? elem_t'(1 << FRAC) : '0;
      res.singular = 1'b1;
      return res;
    end
    res.singular = 1'b0;
    for (int i = 0; i < 9; i++) begin
      sgn = (c[i] < 0) != (det < 0);
      num = ((c[i] < 0) ? -c[i] : c[i]) <<< (2*FRAC);
      q = ((num <<< 1) + ad) / (ad <<< 1);
      if (!sgn && q > 256'sd2147483647) begin
        res.r[i] = 32'sh7fffffff;
        res.saturated = 1'b1;
      end else if (sgn && q > 256'sd2147483648) begin
        res.r[i] = 32'sh80000000;
        res.saturated = 1'b1;
      end else begin
        res.r[i] = sgn ? elem_t'(-q) : elem_t'(q);
      end
    end
    return res;
  endfunction

  function automatic elem_t random_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return elem_t'($signed($urandom_range(0, 255)) - 128);
      default: return elem_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic send_request(mat_t m);
    in_chan.valid <= 1'b1;
    {in_chan.m00, in_chan.m01, in_chan.m02} <= {m[0], m[1], m[2]};
    {in_chan.m10, in_chan.m11, in_chan.m12} <= {m[3], m[4], m[5]};
    {in_chan.m20, in_chan.m21, in_chan.m22} <= {m[6], m[7], m[8]};
    do @(posedge clk); while (!in_chan.ready);
    inverse_queue.push_back(predict_inverse(m, threshold));
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_write(logic [30:0] value);
    in_chan.valid <= 1'b0;
    while (inverse_queue.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    threshold = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    {in_chan.m00, in_chan.m01, in_chan.m02} = '0;
    {in_chan.m10, in_chan.m11, in_chan.m12} = '0;
    {in_chan.m20, in_chan.m21, in_chan.m22} = '0;
  end

  // The receiver stalls on a period that is reshuffled every so often.
  initial begin
    int period;
    int phase;
    out_chan.ready = 1'b0;
    @(negedge rst);
    forever begin
      period = $urandom_range(1, 7);
      phase = 0;
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk);
        out_chan.ready <= (period == 1) || (phase % period != 0)
                          || ($urandom_range(0, 2) == 0);
        phase++;
      end
    end
  end

  always @(posedge clk) begin
    inverse_t got, want;
    if (!rst && out_chan.valid && out_chan.ready) begin
      got.r = '{out_chan.r00, out_chan.r01, out_chan.r02, out_chan.r10, out_chan.r11,
                out_chan.r12, out_chan.r20, out_chan.r21, out_chan.r22};
      got.singular = out_chan.singular;
      got.saturated = out_chan.saturated;
      if (inverse_queue.size() == 0) begin
        $display("%0t: unexpected result r00=%h", $time, got.r[0]);
        errors++;
      end else begin
        want = inverse_queue.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.r[i] !== want.r[i]) begin
            $display("%0t: element %0d expected %h actual %h", $time, i, want.r[i], got.r[i]);
            errors++;
          end
        if (got.singular !== want.singular || got.saturated !== want.saturated) begin
          $display("%0t: flags expected %b%b actual %b%b", $time, want.singular,
                   want.saturated, got.singular, got.saturated);
          errors++;
        end
      end
    end
  end

  function automatic row_t make_row(mat_t m, logic has_lit, inverse_t lit);
    row_t r;
    r.m = m;
    r.has_lit = has_lit;
    r.lit = lit;
    return r;
  endfunction

  initial begin
    mat_t m;
    inverse_t ident, none;
    int done;
    elem_t one, mx, mn;
    logic [30:0] settings [0:3];
    one = 1 << FRAC;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    threshold = 31'd1;
    ident.r = '{one, 0, 0, 0, one, 0, 0, 0, one};
    ident.singular = 1'b1;
    ident.saturated = 1'b0;
    none = ident;
    directed.push_back(make_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ident));
    directed.push_back(make_row('{one, 0, 0, 0, one, 0, 0, 0, one}, 1'b0, none));
    directed.push_back(make_row('{one, one, one, one, one, one, one, one, one}, 1'b1, ident));
    directed.push_back(make_row('{mx, 0, 0, 0, mx, 0, 0, 0, mx}, 1'b0, none));
    directed.push_back(make_row('{mn, 0, 0, 0, mn, 0, 0, 0, mn}, 1'b0, none));
    directed.push_back(make_row('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b1, ident));
    directed.push_back(make_row('{256, 0, 0, 0, 256, 0, 0, 0, 256}, 1'b0, none));
    directed.push_back(make_row('{mx, mn, mx, mn, mx, mn, mx, mx, mn}, 1'b0, none));
    directed.push_back(make_row('{mx, mx, mx, mx, mx, mx, mx, mx, mx}, 1'b1, ident));
    directed.push_back(make_row('{-one, 0, 0, 0, one, 0, 0, 0, -one}, 1'b0, none));
    directed.push_back(make_row('{0, one, 0, one, 0, 0, 0, 0, one}, 1'b0, none));
    directed.push_back(make_row('{3*one, 2, -5, 7, one, 9, -one, 4, 2*one}, 1'b0, none));
    directed.push_back(make_row('{-1, -1, -1, -1, -2, -1, -1, -1, -3}, 1'b0, none));
    settings = '{31'd0, 31'h7fffffff, 31'd65536, 31'd1};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].m);
      if (directed[i].has_lit) inverse_queue[$] = directed[i].lit;
      idle_gap();
    end

    for (int s = 0; s < 4; s++) begin
      drain_and_write(settings[s]);
      if (s == 0) send_request('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      done = 0;
      while (done < 125) begin
        repeat ($urandom_range(1, 20)) begin
          for (int k = 0; k < 9; k++) m[k] = random_elem();
          if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 3; k++) m[6 + k] = m[k];
          end
          send_request(m);
          done++;
        end
        idle_gap();
      end
    end

    in_chan.valid <= 1'b0;
    while (inverse_queue.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
